### sv/scs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the sorted byte set
// Beat structs, request and status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int LIST_LIMIT   = 32;
  localparam int KEY_W        = 8;
  localparam int POS_W        = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_PRESENT  = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_FOUND    = 3'd4,
    STAT_FULL     = 3'd5,
    STAT_ENTRY    = 3'd6,
    STAT_EMPTY    = 3'd7
  } status_t;

  // Command broadcast to the row of cells
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_LIST = 2'd2
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
  } scs_in_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] value;
    logic [POS_W-1:0] total;
    logic             last;
  } scs_out_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
  } scs_cmd_t;

  // Summary of the row seen by the controller
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] rank;
    logic [KEY_W-1:0] head;
  } scs_look_t;

endpackage
`default_nettype wire

### sv/sorted_char_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_char_set: ascending set of distinct bytes in a row of cells
// Insert, delete, search and list requests over a sorted row of slots.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | scs_in_t  {kind, key}
//   rsp     | out | rsp_valid/rsp_stall  | scs_out_t {status, position, value,
//           |     |                      |            total, last}
//
// Insert, delete and search are taken in ST_IDLE and evaluated in ST_EVAL,
// where every cell compares with the key and shifts in parallel once the
// output register is free. A list rotates the row once per stored value,
// the head being emitted on each up to LIST_LIMIT; rsp_stall holds the
// emitting rotations. One request is in flight at a time; a finished result
// may wait in the output register while the next request is taken. Reset
// clears all slots. A list of an empty set gives one STAT_EMPTY beat.
// ----------------------------------------------------------------------------
module sorted_char_set #(
  parameter int CAPACITY = scs_pkg::CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire scs_pkg::scs_in_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output scs_pkg::scs_out_t     rsp
);
  import scs_pkg::*;

  scs_cmd_t         cmd;
  scs_look_t        look;
  logic [KEY_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [POS_W-1:0]    rank;

  scs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .look      (look)
  );

  // Row of cells, slot 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] pv, nv;
    logic             po, pl, no;
    if (i == 0) begin : g_first
      assign pv = cmd.key;
      assign po = 1'b1;
      assign pl = 1'b1;
    end else begin : g_mid
      assign pv = cell_val[i-1];
      assign po = occ_vec[i-1];
      assign pl = lt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv = cell_val[0];
      assign no = 1'b0;
    end else begin : g_inner
      assign nv = cell_val[i+1];
      assign no = occ_vec[i+1];
    end
    scs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .prev_val (pv),
      .prev_occ (po),
      .prev_lt  (pl),
      .next_val (nv),
      .next_occ (no),
      .head_val (cell_val[0]),
      .val      (cell_val[i]),
      .occ      (occ_vec[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i])
    );
  end

  // Rank of the matching slot, 1-based
  always_comb begin
    rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_vec[i]) begin
        rank = rank | POS_W'(i + 1);
      end
    end
  end

  assign look.hit  = |eq_vec;
  assign look.rank = rank;
  assign look.head = cell_val[0];

  // Checks
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq_vec))
    else $error("key matched in more than one slot");

  a_packed_row: assert property (@(posedge clk) disable iff (rst)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("occupied slots are not contiguous from the head");

endmodule
`default_nettype wire

### sv/scs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_cell: one slot of the sorted row
// Holds a value and an occupied flag, compares against the broadcast key and
// shifts toward either neighbor on insert, delete and list rotation.
// ----------------------------------------------------------------------------
module scs_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire scs_pkg::scs_cmd_t       cmd,
  input  wire logic [scs_pkg::KEY_W-1:0] prev_val,
  input  wire logic                    prev_occ,
  input  wire logic                    prev_lt,
  input  wire logic [scs_pkg::KEY_W-1:0] next_val,
  input  wire logic                    next_occ,
  input  wire logic [scs_pkg::KEY_W-1:0] head_val,
  output logic [scs_pkg::KEY_W-1:0]    val,
  output logic                         occ,
  output logic                         lt,
  output logic                         eq
);
  import scs_pkg::*;

  logic [KEY_W-1:0] val_next;
  logic             occ_next;

  // Compare against the broadcast key
  assign lt = occ && (val < cmd.key);
  assign eq = occ && (val == cmd.key);

  // Slot update
  always_comb begin
    val_next = val;
    occ_next = occ;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_INS: begin
        // slots at or above the insertion point move up by one
        if (!lt) begin
          val_next = prev_lt ? cmd.key : prev_val;
          occ_next = occ | prev_occ;
        end
      end
      OP_DEL: begin
        // slots at or above the deleted key pull from above
        if (!lt) begin
          val_next = next_val;
          occ_next = next_occ;
        end
      end
      OP_ROT: begin
        // rotate the occupied segment down; the top one wraps to the head
        val_next = next_occ ? next_val : head_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

### sv/scs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_ctrl: request sequencer and result register
// Takes a request, drives the cell row for one evaluation or for one
// rotation per stored value, and loads result beats into the output register.
// ----------------------------------------------------------------------------
module scs_ctrl #(
  parameter int CAPACITY = scs_pkg::CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire scs_pkg::scs_in_t    req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output scs_pkg::scs_out_t        rsp,
  output scs_pkg::scs_cmd_t        cmd,
  input  wire scs_pkg::scs_look_t  look
);
  import scs_pkg::*;

  localparam int CW      = $clog2(CAPACITY + 1);
  localparam bit LIMITED = CAPACITY > LIST_LIMIT;

  state_t           state, state_next;
  kind_t            kind, kind_next;
  logic [KEY_W-1:0] key, key_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    emit_n;
  logic             out_free;
  logic             load;
  logic             full;
  scs_out_t         beat;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign full      = (count == CW'(CAPACITY));
  assign idx_inc   = idx + 1'b1;
  assign emit_n    = (LIMITED && (count > CW'(LIST_LIMIT))) ? CW'(LIST_LIMIT) : count;

  // Next state, cell command and result beat
  always_comb begin
    state_next = state;
    kind_next  = kind;
    key_next   = key;
    count_next = count;
    idx_next   = idx;
    load       = 1'b0;
    cmd.op     = OP_HOLD;
    cmd.key    = key;
    beat.status   = STAT_ABSENT;
    beat.position = '0;
    beat.value    = key;
    beat.last     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          kind_next  = req.kind;
          key_next   = req.key;
          idx_next   = '0;
          state_next = (req.kind == KIND_LIST) ? ST_LIST : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          unique case (kind)
            KIND_INSERT: begin
              if (look.hit) begin
                beat.status = STAT_PRESENT;
              end else if (full) begin
                beat.status = STAT_FULL;
              end else begin
                cmd.op      = OP_INS;
                count_next  = count + 1'b1;
                beat.status = STAT_INSERTED;
              end
            end
            KIND_DELETE: begin
              if (look.hit) begin
                cmd.op      = OP_DEL;
                count_next  = count - 1'b1;
                beat.status = STAT_DELETED;
              end
            end
            KIND_SEARCH, KIND_LIST: begin
              if (look.hit) begin
                beat.status   = STAT_FOUND;
                beat.position = look.rank;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (count == '0) begin
          if (out_free) begin
            load        = 1'b1;
            beat.status = STAT_EMPTY;
            state_next  = ST_IDLE;
          end
        end else if (idx < emit_n) begin
          // emit the head, then rotate it to the top
          if (out_free) begin
            load          = 1'b1;
            beat.status   = STAT_ENTRY;
            beat.position = POS_W'(idx_inc);
            beat.value    = look.head;
            beat.last     = (idx_inc == emit_n);
            cmd.op        = OP_ROT;
            idx_next      = idx_inc;
            if (idx_inc == count) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          // entries past the list limit: rotate back into order silently
          cmd.op   = OP_ROT;
          idx_next = idx_inc;
          if (idx_inc == count) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    beat.total = POS_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    kind <= kind_next;
    key  <= key_next;
    if (load) begin
      rsp <= beat;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INS) |=> (count == $past(count) + 1'b1))
    else $error("insert did not bump the count");

  a_rot_in_list: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ROT) |-> (state == ST_LIST) && (count != '0))
    else $error("rotation outside a list walk");

endmodule
`default_nettype wire

### tb/sv/sorted_char_set_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_char_set_chk: result checker for the sorted byte set
// Watches both channels. Each accepted request updates a shadow copy of the
// sorted set and queues the results it must produce. Each accepted result
// beat is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module sorted_char_set_chk #(
  parameter int CAPACITY = scs_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  scs_pkg::scs_in_t  req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  scs_pkg::scs_out_t rsp,
  output int                mismatch_count,
  output int                open_rsp
);
  import scs_pkg::*;

  // Shadow of the set: ascending values in slots 0 .. stored-1
  logic [KEY_W-1:0] slot_val [CAPACITY];
  int unsigned      stored;
  scs_out_t         due_rsp_q [$];

  // total is taken after the set has been updated
  function automatic scs_out_t make_rsp(status_t st, int unsigned pos,
                                        logic [KEY_W-1:0] val, logic fin);
    scs_out_t r;
    r.status   = st;
    r.position = POS_W'(pos);
    r.value    = val;
    r.total    = POS_W'(stored);
    r.last     = fin;
    return r;
  endfunction

  // Apply one request to the shadow set and queue its results
  function automatic void apply_request(scs_in_t beat);
    int unsigned rank;
    int unsigned n;
    int unsigned i;
    logic        hit;
    rank = 0;
    if (beat.kind == KIND_LIST) begin
      n = (stored < LIST_LIMIT) ? stored : LIST_LIMIT;
      if (n == 0) begin
        due_rsp_q.push_back(make_rsp(STAT_EMPTY, 0, beat.key, 1'b1));
      end
      for (i = 0; i < n; i++) begin
        due_rsp_q.push_back(make_rsp(STAT_ENTRY, i + 1, slot_val[i], (i + 1) == n));
      end
      return;
    end
    // first slot not below the key
    while (rank < stored && slot_val[rank] < beat.key) rank++;
    hit = (rank < stored) && (slot_val[rank] == beat.key);
    case (beat.kind)
      KIND_INSERT: begin
        if (hit) begin
          due_rsp_q.push_back(make_rsp(STAT_PRESENT, 0, beat.key, 1'b1));
        end else if (stored >= CAPACITY) begin
          due_rsp_q.push_back(make_rsp(STAT_FULL, 0, beat.key, 1'b1));
        end else begin
          for (i = stored; i > rank; i--) slot_val[i] = slot_val[i-1];
          slot_val[rank] = beat.key;
          stored++;
          due_rsp_q.push_back(make_rsp(STAT_INSERTED, 0, beat.key, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          for (i = rank; i + 1 < stored; i++) slot_val[i] = slot_val[i+1];
          stored--;
          due_rsp_q.push_back(make_rsp(STAT_DELETED, 0, beat.key, 1'b1));
        end else begin
          due_rsp_q.push_back(make_rsp(STAT_ABSENT, 0, beat.key, 1'b1));
        end
      end
      default: begin
        if (hit) due_rsp_q.push_back(make_rsp(STAT_FOUND, rank + 1, beat.key, 1'b1));
        else     due_rsp_q.push_back(make_rsp(STAT_ABSENT, 0, beat.key, 1'b1));
      end
    endcase
  endfunction

  // Result beats are checked before the request of the same edge is applied
  always @(posedge clk) begin
    scs_out_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      due_rsp_q.delete();
      stored = 0;
      mismatch_count <= 0;
      open_rsp       <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp_q.size() == 0) begin
          $error("unexpected result beat %p", rsp);
          errs++;
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("rsp.status expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.position !== want.position) begin
            $error("rsp.position expected %0d, got %0d", want.position, rsp.position);
            errs++;
          end
          if (rsp.value !== want.value) begin
            $error("rsp.value expected 0x%02h, got 0x%02h", want.value, rsp.value);
            errs++;
          end
          if (rsp.total !== want.total) begin
            $error("rsp.total expected %0d, got %0d", want.total, rsp.total);
            errs++;
          end
          if (rsp.last !== want.last) begin
            $error("rsp.last expected %0d, got %0d", want.last, rsp.last);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall) apply_request(req);
      mismatch_count <= mismatch_count + errs;
      open_rsp       <= due_rsp_q.size();
    end
  end

endmodule

### tb/sv/sorted_char_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_char_set_tb: top of the sorted byte set testbench
// Drives directed and random request beats under several idle and stall
// mixes, stalls the result channel, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module sorted_char_set_tb;
  import scs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * LIST_LIMIT + 16;
  localparam int BLOCKS         = 8;
  localparam int BLOCK_ITEMS    = 56;
  localparam int KEY_SPAN       = 47;

  // Random request mixes
  typedef enum int {
    MIX_FILL  = 0,
    MIX_BOTH  = 1,
    MIX_DRAIN = 2
  } mix_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  scs_in_t  req       = '0;
  logic     req_stall;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  scs_out_t rsp;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int mismatch_count;
  int open_rsp;

  always #2 clk = ~clk;

  sorted_char_set u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sorted_char_set_chk u_chk (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .open_rsp       (open_rsp)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(input kind_t kind, input logic [KEY_W-1:0] key);
    while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{kind: kind, key: key};
    do @(posedge clk); while (req_stall);
  endtask

  // Stop sending until every queued result has come back
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_rsp != 0) @(posedge clk);
  endtask

  initial begin
    int               blk;
    int               n;
    int               pick;
    mix_t             mix;
    kind_t            kind;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, key extremes, duplicates, misses, head and tail
    send_beat(KIND_LIST,   8'hFF);
    send_beat(KIND_LIST,   8'h00);
    send_beat(KIND_SEARCH, 8'h55);
    send_beat(KIND_DELETE, 8'hAA);
    send_beat(KIND_INSERT, 8'h80);
    send_beat(KIND_INSERT, 8'h00);
    send_beat(KIND_INSERT, 8'hFF);
    send_beat(KIND_INSERT, 8'h00);
    send_beat(KIND_INSERT, 8'h7F);
    send_beat(KIND_SEARCH, 8'h00);
    send_beat(KIND_SEARCH, 8'hFF);
    send_beat(KIND_SEARCH, 8'h80);
    send_beat(KIND_SEARCH, 8'h81);
    send_beat(KIND_LIST,   8'h33);
    send_beat(KIND_DELETE, 8'h81);
    send_beat(KIND_DELETE, 8'h00);
    send_beat(KIND_DELETE, 8'hFF);
    send_beat(KIND_LIST,   8'hCC);
    send_beat(KIND_DELETE, 8'h80);
    send_beat(KIND_DELETE, 8'h7F);
    send_beat(KIND_LIST,   8'h5A);
    hold_until_drained();

    // Random blocks: keys mostly from a narrow window so the set fills up,
    // runs full, and then drains with real hits
    base = 8'($urandom_range(255));
    for (blk = 0; blk < BLOCKS; blk++) begin
      mix = mix_t'(blk % 3);
      if (mix == MIX_FILL) base = 8'($urandom_range(255));
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          kind = KIND_LIST;
        end else begin
          case (mix)
            MIX_FILL:  kind = (pick < 72) ? KIND_INSERT : (pick < 84) ? KIND_DELETE : KIND_SEARCH;
            MIX_DRAIN: kind = (pick < 18) ? KIND_INSERT : (pick < 78) ? KIND_DELETE : KIND_SEARCH;
            default:   kind = (pick < 38) ? KIND_INSERT : (pick < 68) ? KIND_DELETE : KIND_SEARCH;
          endcase
        end
        if ($urandom_range(99) < 85) key = base + 8'($urandom_range(KEY_SPAN));
        else                          key = 8'($urandom_range(255));
        send_beat(kind, key);
      end
      hold_until_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && open_rsp == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/scs_pkg.sv
sv/scs_cell.sv
sv/scs_ctrl.sv
sv/sorted_char_set.sv
tb/sv/sorted_char_set_chk.sv
tb/sv/sorted_char_set_tb.sv
